### rtl/core/cws_pkg.sv
// shared types and constants for the command-line word splitter
`timescale 1ns / 1ps

package cws_pkg;

   // parser modes
   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_SEP    = 3'd1,
      MODE_ESC    = 3'd2,
      MODE_DQ     = 3'd3,
      MODE_SQ     = 3'd4
   } mode_type;

   // result kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_ARG_END = 2'd1;
   localparam logic [1:0] KIND_CMD_END = 2'd2;

   // special bytes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // parser state
   typedef struct packed {
      mode_type   mode;
      mode_type   saved;
      logic       pending;
      logic [7:0] count;
   } state_type;

   // one result item
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] arg_index;
      logic       last;
   } rsp_type;

   // everything one input byte produces
   typedef struct packed {
      state_type  nxt;
      logic [1:0] n;
      rsp_type    r0;
      rsp_type    r1;
      logic       cmd_end;
   } step_type;

endpackage

### rtl/core/cws_req_if.sv
// input channel interface: command bytes
`timescale 1ns / 1ps

interface cws_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       finish;

   modport source (output valid, output ch, output finish, input ready);
   modport sink (input valid, input ch, input finish, output ready);
endinterface

### rtl/core/cws_rsp_if.sv
// result channel interface: argument bytes and marks
`timescale 1ns / 1ps

interface cws_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [7:0] arg_index;
   logic       last;

   modport source (output valid, output kind, output out_byte, output arg_index,
                   output last, input ready);
   modport sink (input valid, input kind, input out_byte, input arg_index,
                 input last, output ready);
endinterface

### rtl/core/command_line_word_splitter_top.sv
// top level of the command-line word splitter
// Splits a stream of command bytes into arguments. Each accepted byte is held in
// an input register, parsed against the parser state and written as zero, one
// or two result transfers into a two-entry result buffer. A new byte is taken
// every cycle while results drain one per cycle and no byte yields two results;
// a byte that yields two (an argument end plus a byte or a command end) holds
// off the next byte until its second result drains through the single result
// port. Each byte passes the input register and then the result buffer before
// its first result appears. finish or a zero byte ends the command: a pending
// argument is closed, a command-end mark follows, and the parser returns to its
// reset state. Argument indexes saturate at min(MAX_ARGS, 255).
`timescale 1ns / 1ps

module command_line_word_splitter_top #(
   parameter int MAX_ARGS = 255
) (
   input logic     clock,
   input logic     reset,
   cws_req_if.sink   req_chan,
   cws_rsp_if.source rsp_chan
);
   import cws_pkg::*;

   localparam logic [7:0] ARG_CAP = 8'((MAX_ARGS < 255) ? MAX_ARGS : 255);

   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_finish_ff;
   state_type  state_ff;
   rsp_type    slot0_ff;
   rsp_type    slot1_ff;
   logic [1:0] cnt_ff;
   step_type   step;
   logic       pop;
   logic       move;

   // parser step
   cws_step #(
      .MAX_ARGS (MAX_ARGS)
   ) u_step (
      .cur    (state_ff),
      .ch     (in_ch_ff),
      .finish (in_finish_ff),
      .step   (step)
   );

   // handshake control
   assign pop  = rsp_chan.ready && (cnt_ff != 2'd0);
   assign move = in_valid_ff && ((cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop));
   assign req_chan.ready = !in_valid_ff || move;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_ch_ff     <= req_chan.ch;
         in_finish_ff <= req_chan.finish;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_NORMAL, saved: MODE_NORMAL, pending: 1'b0, count: 8'd0};
      end else if (move) begin
         state_ff <= step.nxt;
      end
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (move) begin
         cnt_ff <= step.n;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
      if (move) begin
         slot0_ff <= step.r0;
         slot1_ff <= step.r1;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

   // result transfer
   assign rsp_chan.valid     = (cnt_ff != 2'd0);
   assign rsp_chan.kind      = slot0_ff.kind;
   assign rsp_chan.out_byte  = slot0_ff.out_byte;
   assign rsp_chan.arg_index = slot0_ff.arg_index;
   assign rsp_chan.last      = slot0_ff.last;

   // checks
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= ARG_CAP)
      else $error("argument count beyond cap");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !slot0_ff.last && slot1_ff.last)
      else $error("result pair out of order");

   a_cmd_reset: assert property (@(posedge clock) disable iff (reset)
      move && step.cmd_end |=> state_ff.mode == MODE_NORMAL && state_ff.count == 8'd0
         && !state_ff.pending && rsp_chan.valid)
      else $error("command end did not restore parser");

   a_buf_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !move)
      else $error("result buffer overrun");

endmodule

### rtl/core/cws_step.sv
// combinational parser step: next state and up to two results for one byte
`timescale 1ns / 1ps

module cws_step #(
   parameter int MAX_ARGS = 255
) (
   input  cws_pkg::state_type cur,
   input  logic [7:0]         ch,
   input  logic               finish,
   output cws_pkg::step_type  step
);
   import cws_pkg::*;

   localparam logic [7:0] ARG_CAP = 8'((MAX_ARGS < 255) ? MAX_ARGS : 255);

   logic       do_close;
   logic       do_append;
   logic       do_cmd;
   logic       close_hit;
   mode_type   mode_nx;
   mode_type   saved_nx;
   logic [7:0] count_cl;
   rsp_type    e_close;
   rsp_type    e_app;
   rsp_type    e_cmd;

   // mode decisions
   always_comb begin
      do_close  = 1'b0;
      do_append = 1'b0;
      do_cmd    = 1'b0;
      mode_nx   = cur.mode;
      saved_nx  = cur.saved;
      if (finish || ch == CH_NUL) begin
         do_close = 1'b1;
         do_cmd   = 1'b1;
      end else begin
         case (ch)
            CH_BSLASH: begin
               case (cur.mode)
                  MODE_SEP: begin
                     do_close = 1'b1;
                     mode_nx  = MODE_ESC;
                     saved_nx = MODE_NORMAL;
                  end
                  MODE_NORMAL, MODE_DQ: begin
                     saved_nx = cur.mode;
                     mode_nx  = MODE_ESC;
                  end
                  MODE_ESC: begin
                     mode_nx   = cur.saved;
                     do_append = 1'b1;
                  end
                  MODE_SQ: ;
                  default: begin
                     saved_nx = MODE_NORMAL;
                     mode_nx  = MODE_ESC;
                  end
               endcase
            end
            CH_DQUOTE: begin
               case (cur.mode)
                  MODE_SEP: begin
                     do_close = 1'b1;
                     mode_nx  = MODE_DQ;
                  end
                  MODE_ESC: begin
                     mode_nx   = cur.saved;
                     do_append = 1'b1;
                  end
                  MODE_DQ: mode_nx = MODE_NORMAL;
                  MODE_SQ: do_append = 1'b1;
                  default: begin
                     saved_nx = MODE_NORMAL;
                     mode_nx  = MODE_DQ;
                  end
               endcase
            end
            CH_SQUOTE: begin
               case (cur.mode)
                  MODE_ESC: begin
                     do_append = 1'b1;
                     mode_nx   = cur.saved;
                  end
                  MODE_SEP: begin
                     do_close = 1'b1;
                     mode_nx  = MODE_SQ;
                  end
                  MODE_DQ: do_append = 1'b1;
                  MODE_SQ: mode_nx = cur.saved;
                  default: begin
                     saved_nx = MODE_NORMAL;
                     mode_nx  = MODE_SQ;
                  end
               endcase
            end
            CH_SPACE: begin
               case (cur.mode)
                  MODE_SEP: ;
                  MODE_ESC: begin
                     do_append = 1'b1;
                     mode_nx   = cur.saved;
                  end
                  MODE_DQ, MODE_SQ: do_append = 1'b1;
                  default: mode_nx = MODE_SEP;
               endcase
            end
            default: begin
               case (cur.mode)
                  MODE_SEP: begin
                     do_close  = 1'b1;
                     do_append = 1'b1;
                     mode_nx   = MODE_NORMAL;
                  end
                  MODE_ESC: begin
                     do_append = 1'b1;
                     mode_nx   = cur.saved;
                  end
                  MODE_DQ, MODE_SQ: do_append = 1'b1;
                  default: begin
                     do_append = 1'b1;
                     mode_nx   = MODE_NORMAL;
                  end
               endcase
            end
         endcase
      end
   end

   // argument close and saturating index
   assign close_hit = do_close && cur.pending;
   assign count_cl  = (close_hit && cur.count < ARG_CAP) ? cur.count + 8'd1 : cur.count;

   // candidate result items
   always_comb begin
      e_close = '{kind: KIND_ARG_END, out_byte: 8'd0, arg_index: cur.count, last: 1'b0};
      e_app   = '{kind: KIND_BYTE, out_byte: ch, arg_index: count_cl, last: 1'b0};
      e_cmd   = '{kind: KIND_CMD_END, out_byte: 8'd0, arg_index: count_cl, last: 1'b0};
   end

   // pack results in order and build next state
   always_comb begin
      step         = '0;
      step.cmd_end = do_cmd;
      if (close_hit) begin
         step.r0 = e_close;
         if (do_append) begin
            step.r1 = e_app;
            step.n  = 2'd2;
         end else if (do_cmd) begin
            step.r1 = e_cmd;
            step.n  = 2'd2;
         end else begin
            step.n = 2'd1;
         end
      end else if (do_append) begin
         step.r0 = e_app;
         step.n  = 2'd1;
      end else if (do_cmd) begin
         step.r0 = e_cmd;
         step.n  = 2'd1;
      end
      step.r0.last = (step.n == 2'd1);
      step.r1.last = 1'b1;

      if (do_cmd) begin
         step.nxt.mode    = MODE_NORMAL;
         step.nxt.saved   = MODE_NORMAL;
         step.nxt.pending = 1'b0;
         step.nxt.count   = 8'd0;
      end else begin
         step.nxt.mode    = mode_nx;
         step.nxt.saved   = saved_nx;
         step.nxt.pending = do_append ? 1'b1 : (close_hit ? 1'b0 : cur.pending);
         step.nxt.count   = count_cl;
      end
   end

endmodule
